### rtl/core/spq_pkg.sv
// spq_pkg: shared types and constants for the sorted priority queue core
// used by spq_cell, sorted_priority_queue_core and spq_checker; no dependencies
package spq_pkg;

  // queue depth and derived widths
  localparam int CAPACITY = 16;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int PRIO_W   = 16;
  localparam int PAYLOAD_W = 32;

  // operation codes carried on the mode field
  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_EXTRACT = 2'd1,
    MODE_PEEK    = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // one stored entry
  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [PAYLOAD_W-1:0]     payload;
  } slot_t;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic                     insert_en;
    logic                     extract_en;
    logic signed [PRIO_W-1:0] new_prio;
    logic [PAYLOAD_W-1:0]     new_payload;
  } cell_ctrl_t;

endpackage

### rtl/core/spq_cell.sv
// spq_cell: one slot of the sorted row, compares against the broadcast entry
// and shifts with its neighbors; depends on spq_pkg
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               occupied,
  input  logic               left_keep,
  input  spq_pkg::slot_t     left_slot,
  input  spq_pkg::slot_t     right_slot,
  output logic               keep,
  output spq_pkg::slot_t     slot,
  output spq_pkg::slot_t     slot_next
);

  // stored entry stays put when it sorts at or before the new one
  assign keep = occupied && ($signed(slot.prio) <= $signed(ctrl.new_prio));

  // insert: hold, take the new entry, or shift in from the left; extract: shift in from the right
  always_comb begin
    slot_next = slot;
    if (ctrl.insert_en) begin
      if (keep) begin
        slot_next = slot;
      end else if (left_keep) begin
        slot_next.prio    = ctrl.new_prio;
        slot_next.payload = ctrl.new_payload;
      end else begin
        slot_next = left_slot;
      end
    end else if (ctrl.extract_en) begin
      slot_next = right_slot;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

### rtl/core/sorted_priority_queue_core.sv
// sorted_priority_queue_core: top level, row of spq_cell slots with fill count
// and a registered result stage; depends on spq_pkg and spq_cell
//
// Bounded priority queue of spq_pkg::CAPACITY entries kept in ascending signed
// priority order, equal priorities in arrival order. Each input transaction is
// an insert, extract front, peek front or clear, and yields exactly one result
// transaction carrying status, entry count, full flag and the head entry (the
// removed entry on extract). Every slot compares and shifts in parallel, so a
// transaction updates the whole row together: the block takes one
// transaction per cycle while the output is not stalled, and the result
// appears in the output register on the cycle after acceptance. The output
// register holds a result while the consumer stalls; a new transaction is
// taken in the same cycle that the held result leaves. Slots above the fill
// count are never read, so no clearing pass follows reset.
module sorted_priority_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic signed [15:0] entry_priority,
  input  logic [31:0] entry_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        head_valid,
  output logic signed [15:0] head_priority,
  output logic [31:0] head_payload,
  output logic [4:0]  entry_count,
  output logic        is_full
);

  localparam int Cap = spq_pkg::CAPACITY;

  logic [spq_pkg::COUNT_W-1:0] count;
  logic [spq_pkg::COUNT_W-1:0] count_next;
  spq_pkg::cell_ctrl_t         ctrl;
  spq_pkg::slot_t              slots      [Cap];
  spq_pkg::slot_t              slots_next [Cap];
  logic [Cap-1:0]              keeps;
  logic                        accept;
  spq_pkg::mode_t              op;
  logic                        is_empty;
  logic                        at_cap;
  logic [1:0]                  status_next;
  logic                        head_valid_next;
  spq_pkg::slot_t              head_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign op       = spq_pkg::mode_t'(mode);
  assign is_empty = (count == '0);
  assign at_cap   = (count == spq_pkg::COUNT_W'(Cap));

  // broadcast control to the row
  always_comb begin
    ctrl.insert_en   = accept && (op == spq_pkg::MODE_INSERT) && !at_cap;
    ctrl.extract_en  = accept && (op == spq_pkg::MODE_EXTRACT) && !is_empty;
    ctrl.new_prio    = entry_priority;
    ctrl.new_payload = entry_payload;
  end

  // row of cells, each handing its slot to both neighbors
  for (genvar i = 0; i < Cap; i++) begin : g_cell
    logic           occ;
    logic           lkeep;
    spq_pkg::slot_t lslot;
    spq_pkg::slot_t rslot;

    assign occ = (count > spq_pkg::COUNT_W'(i));
    if (i == 0) begin : g_first
      assign lkeep = 1'b1;
      assign lslot = slots[i];
    end else begin : g_mid
      assign lkeep = keeps[i-1];
      assign lslot = slots[i-1];
    end
    if (i == Cap - 1) begin : g_last
      assign rslot = slots[i];
    end else begin : g_notlast
      assign rslot = slots[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occ),
      .left_keep (lkeep),
      .left_slot (lslot),
      .right_slot(rslot),
      .keep      (keeps[i]),
      .slot      (slots[i]),
      .slot_next (slots_next[i])
    );
  end

  // fill count and result for the accepted transaction
  always_comb begin
    count_next      = count;
    status_next     = spq_pkg::STATUS_DONE;
    head_valid_next = 1'b0;
    head_next       = '0;
    case (op)
      spq_pkg::MODE_INSERT: begin
        if (at_cap) begin
          status_next = spq_pkg::STATUS_FULL;
        end else begin
          count_next = count + spq_pkg::COUNT_W'(1);
        end
      end
      spq_pkg::MODE_EXTRACT: begin
        if (is_empty) begin
          status_next = spq_pkg::STATUS_EMPTY;
        end else begin
          count_next = count - spq_pkg::COUNT_W'(1);
        end
      end
      spq_pkg::MODE_PEEK: begin
        count_next = count;
      end
      spq_pkg::MODE_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
    // extract reports the removed entry, others the front after the update
    if (op == spq_pkg::MODE_EXTRACT) begin
      if (!is_empty) begin
        head_valid_next = 1'b1;
        head_next       = slots[0];
      end
    end else if (count_next != '0) begin
      head_valid_next = 1'b1;
      head_next       = slots_next[0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= status_next;
      head_valid    <= head_valid_next;
      head_priority <= head_next.prio;
      head_payload  <= head_next.payload;
      entry_count   <= 5'(count_next);
      is_full       <= (count_next == spq_pkg::COUNT_W'(Cap));
    end
  end

endmodule

### rtl/core/spq_checker.sv
// spq_checker: port-level assertions for sorted_priority_queue_core, with bind
// depends on spq_pkg
module spq_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic        head_valid,
  input logic signed [15:0] head_priority,
  input logic [31:0] head_payload,
  input logic [4:0]  entry_count,
  input logic        is_full
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count))
    else $error("result changed while stalled");

  // full flag agrees with the count
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_full == (entry_count == 5'(spq_pkg::CAPACITY))))
    else $error("is_full disagrees with entry_count");

  // rejected insert only when the queue is full
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == spq_pkg::STATUS_FULL) |-> is_full && head_valid)
    else $error("insert rejected while not full");

  // empty head carries zeros
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !head_valid |-> (head_priority == '0) && (head_payload == '0))
    else $error("invalid head not zero");

  // an empty-extract result leaves the count at zero
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == spq_pkg::STATUS_EMPTY) |-> (entry_count == '0) && !head_valid)
    else $error("empty extract with entries");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .head_valid   (head_valid),
  .head_priority(head_priority),
  .head_payload (head_payload),
  .entry_count  (entry_count),
  .is_full      (is_full)
);
